@@ src/bdq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the bounded deque with search.
package bdq_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned NRES_W      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        OP_CLEAR      = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4,
        OP_SEARCH     = 3'd5,
        OP_LIST_ALL   = 3'd6,
        OP_LIST_EVEN  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } t_state;

endpackage

@@ src/bdq_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command items and result items.
interface bdq_in_if;
    import bdq_pkg::*;

    logic                     valid;
    logic                     ready;
    t_op                      op;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface bdq_out_if;
    import bdq_pkg::*;

    logic                     valid;
    logic                     ready;
    t_status                  status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic                     last;

    modport source (output valid, output status, output data, output position, output last,
                    input ready);
    modport sink   (input valid, input status, input data, input position, input last,
                    output ready);
endinterface

@@ src/bounded_deque_with_search_core.sv @@
`timescale 1ns / 1ps
// Bounded deque of signed words with linear search and listing.
//
// Usage: command items (op, value) enter on i_in; result items (status, data,
// position, last) leave on o_out. Every command gives at least one result, and
// the final result of a command carries last = 1.
// Clear, push and pop: the command is taken and the state is updated in
// S_IDLE, and the result is loaded into the output register in S_FINISH once
// that register is free. Search and list walk the stored elements through the
// registered-read synchronous memory, one element per cycle unless the walk
// stalls; list of N elements emits at most 16 results.
// A new command is taken only when the previous one has loaded its final
// result; that result may still wait in the output register while the next
// command is accepted.
// When the receiver stalls, the output register holds its item, and a walk
// with a result waiting freezes, re-reading its element until the item can move.
// Reset empties the deque (front and count to zero) and drops any pending
// result; the element memory is not cleared and needs no clearing pass.
module bounded_deque_with_search_core #(
    parameter int unsigned DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bdq_in_if.sink        i_in,
    bdq_out_if.source     o_out
);
    import bdq_pkg::*;

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W = IDX_W + 1;

    // Element memory: one write port, one registered read port.
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    t_state                    r_state,  n_state;
    logic [IDX_W-1:0]          r_front,  n_front;
    logic [CNT_W-1:0]          r_count,  n_count;
    logic [IDX_W-1:0]          r_eidx,   n_eidx;
    logic [NRES_W-1:0]         r_nres,   n_nres;
    logic [DATA_W-1:0]         r_key,    n_key;
    t_op                       r_op,     n_op;
    t_status                   r_h_status, n_h_status;
    logic [DATA_W-1:0]         r_h_data,   n_h_data;
    logic [POS_W-1:0]          r_h_pos,    n_h_pos;
    logic                      r_out_valid,  n_out_valid;
    t_status                   r_out_status, n_out_status;
    logic [DATA_W-1:0]         r_out_data,   n_out_data;
    logic [POS_W-1:0]          r_out_pos,    n_out_pos;
    logic                      r_out_last,   n_out_last;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              out_free;
    logic              accept;
    logic              full;
    logic              qualify;
    logic              need_emit;
    logic              at_end;

    function automatic logic [IDX_W-1:0] f_slot(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] ofs);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign out_free       = !r_out_valid || o_out.ready;
    assign i_in.ready     = (r_state == S_IDLE);
    assign accept         = i_in.valid && (r_state == S_IDLE);
    assign full           = (r_count == CNT_W'(DEPTH));

    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_out_status;
    assign o_out.data     = r_out_data;
    assign o_out.position = r_out_pos;
    assign o_out.last     = r_out_last;

    // Element test for the walk, on the word read in the previous cycle.
    always_comb begin
        case (r_op)
            OP_SEARCH:    qualify = (r_rd_data == r_key);
            OP_LIST_ALL:  qualify = 1'b1;
            OP_LIST_EVEN: qualify = !r_rd_data[0];
            default:      qualify = 1'b0;
        endcase
        need_emit = qualify && (r_op != OP_SEARCH) && (r_nres != '0);
        at_end    = (CNT_W'(r_eidx) == r_count - CNT_W'(1))
                 || (qualify && (r_op == OP_SEARCH))
                 || (qualify && (r_nres == NRES_W'(MAX_RESULTS - 1)));
    end

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_eidx       = r_eidx;
        n_nres       = r_nres;
        n_key        = r_key;
        n_op         = r_op;
        n_h_status   = r_h_status;
        n_h_data     = r_h_data;
        n_h_pos      = r_h_pos;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_pos    = r_out_pos;
        n_out_last   = r_out_last;
        rd_en        = 1'b0;
        rd_addr      = r_front;
        wr_en        = 1'b0;
        wr_addr      = r_front;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_h_status = ST_OK;
                    n_h_data   = '0;
                    n_h_pos    = '0;
                    n_state    = S_FINISH;
                    case (i_in.op)
                        OP_CLEAR: begin
                            n_front = '0;
                            n_count = '0;
                        end
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                n_h_status = ST_FULL;
                            end else begin
                                n_front = (r_front == '0) ? IDX_W'(DEPTH - 1)
                                                          : r_front - IDX_W'(1);
                                wr_en   = 1'b1;
                                wr_addr = n_front;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (full) begin
                                n_h_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = f_slot(r_front, IDX_W'(r_count));
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_h_status = ST_MISS;
                            end else begin
                                n_front = (r_front == IDX_W'(DEPTH - 1)) ? '0
                                                                         : r_front + IDX_W'(1);
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_h_status = ST_MISS;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        default: begin
                            // search and list: start the walk at the front
                            n_h_status = ST_MISS;
                            n_nres     = '0;
                            n_key      = i_in.value;
                            n_op       = i_in.op;
                            n_eidx     = '0;
                            if (r_count != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = r_front;
                                n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (need_emit && !out_free) begin
                    // stall: re-read the current element to keep it
                    rd_en   = 1'b1;
                    rd_addr = f_slot(r_front, r_eidx);
                end else begin
                    if (qualify) begin
                        if (need_emit) begin
                            n_out_valid  = 1'b1;
                            n_out_status = r_h_status;
                            n_out_data   = r_h_data;
                            n_out_pos    = r_h_pos;
                            n_out_last   = 1'b0;
                        end
                        n_h_status = ST_OK;
                        n_h_data   = (r_op == OP_SEARCH) ? '0 : r_rd_data;
                        n_h_pos    = POS_W'(r_eidx);
                        n_nres     = r_nres + NRES_W'(1);
                    end
                    if (at_end) begin
                        n_state = S_FINISH;
                    end else begin
                        n_eidx  = r_eidx + IDX_W'(1);
                        rd_en   = 1'b1;
                        rd_addr = f_slot(r_front, n_eidx);
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_h_status;
                    n_out_data   = r_h_data;
                    n_out_pos    = r_h_pos;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_in.value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eidx       <= n_eidx;
        r_nres       <= n_nres;
        r_key        <= n_key;
        r_op         <= n_op;
        r_h_status   <= n_h_status;
        r_h_data     <= n_h_data;
        r_h_pos      <= n_h_pos;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_pos    <= n_out_pos;
        r_out_last   <= n_out_last;
    end

endmodule

@@ src/bdq_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the deque core, bound to its top level.
module bdq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [1:0]                        i_out_status,
    input logic [bdq_pkg::DATA_W-1:0]        i_out_data,
    input logic [bdq_pkg::POS_W-1:0]         i_out_position,
    input logic                              i_out_last
);
    import bdq_pkg::*;

    // Reset drops any pending result.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_out_valid) && !$past(i_out_ready)
            |-> i_out_valid && $stable(i_out_data) && $stable(i_out_status)
                && $stable(i_out_position) && $stable(i_out_last))
        else $error("stalled result changed");

    // Only the final result of a listing may carry a failing status.
    a_mid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> i_out_status == ST_OK)
        else $error("non-final result with failing status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_OK
            |-> i_out_data == '0 && i_out_position == '0
                && i_out_status != ST_RSVD)
        else $error("failing result carries payload");

endmodule

bind bounded_deque_with_search_core bdq_checker u_bdq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_status   (o_out.status),
    .i_out_data     (o_out.data),
    .i_out_position (o_out.position),
    .i_out_last     (o_out.last)
);
